### rtl/grid_wall_follower_assert.svh
// Assertion macros for the grid wall follower
`ifndef GRID_WALL_FOLLOWER_ASSERT_SVH
`define GRID_WALL_FOLLOWER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GWF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("grid_wall_follower: property violated");
`define GWF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("grid_wall_follower: forbidden condition seen");
`else
`define GWF_ASSERT(lbl, clk, rst_n, prop)
`define GWF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/gwf_pkg.sv
// Shared types, constants and helper functions of the grid wall follower
`timescale 1ns / 1ps
package gwf_pkg;

	localparam int GRID_SIDE = 16;
	localparam int GRID_LIM  = (GRID_SIDE < 16) ? GRID_SIDE : 16;
	localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CODE_W    = 3;

	typedef logic [3:0]        pos_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [1:0]        dir_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam code_t CODE_OPEN    = 3'd0;
	localparam code_t CODE_WALL    = 3'd1;
	localparam code_t CODE_VISITED = 3'd2;
	localparam code_t CODE_BACK    = 3'd3;
	localparam code_t CODE_END     = 3'd4;

	localparam dir_t DIR_NORTH = 2'd0;
	localparam dir_t DIR_EAST  = 2'd1;
	localparam dir_t DIR_SOUTH = 2'd2;
	localparam dir_t DIR_WEST  = 2'd3;

	localparam dir_t TURN_NONE   = 2'd0;
	localparam dir_t TURN_RIGHT  = 2'd1;
	localparam dir_t TURN_AROUND = 2'd2;
	localparam dir_t TURN_LEFT   = 2'd3;

	localparam logic [1:0] TRY_RIGHT    = 2'd0;
	localparam logic [1:0] TRY_STRAIGHT = 2'd1;
	localparam logic [1:0] TRY_LEFT     = 2'd2;

	localparam logic [1:0] REG_START_ROW = 2'd0;
	localparam logic [1:0] REG_START_COL = 2'd1;
	localparam logic [1:0] REG_EXIT_ROW  = 2'd2;
	localparam logic [1:0] REG_EXIT_COL  = 2'd3;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_STEP  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_PROBE,
		ST_OUT
	} state_t;

	typedef struct packed {
		kind_t kind;
		pos_t  row;
		pos_t  col;
		code_t code;
	} req_t;

	typedef struct packed {
		pos_t start_row;
		pos_t start_col;
		pos_t exit_row;
		pos_t exit_col;
	} cfg_t;

	typedef struct packed {
		pos_t  row;
		pos_t  col;
		dir_t  heading;
		code_t read_code;
		logic  at_exit;
	} res_t;

	function automatic logic in_grid(input logic [4:0] r, input logic [4:0] c);
		return !r[4] && !c[4] && ({1'b0, r[3:0]} < 5'(GRID_LIM)) &&
			({1'b0, c[3:0]} < 5'(GRID_LIM));
	endfunction

	function automatic addr_t cell_addr(input pos_t r, input pos_t c);
		return ADDR_W'(int'(r) * GRID_SIDE + int'(c));
	endfunction

	function automatic dir_t turn_of(input logic [1:0] t);
		dir_t d;
		case (t)
			TRY_RIGHT:    d = TURN_RIGHT;
			TRY_STRAIGHT: d = TURN_NONE;
			default:      d = TURN_LEFT;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] step_row(input pos_t r, input dir_t h);
		logic [4:0] n;
		case (h)
			DIR_NORTH: n = {1'b0, r} - 5'd1;
			DIR_SOUTH: n = {1'b0, r} + 5'd1;
			default:   n = {1'b0, r};
		endcase
		return n;
	endfunction

	function automatic logic [4:0] step_col(input pos_t c, input dir_t h);
		logic [4:0] n;
		case (h)
			DIR_EAST: n = {1'b0, c} + 5'd1;
			DIR_WEST: n = {1'b0, c} - 5'd1;
			default:  n = {1'b0, c};
		endcase
		return n;
	endfunction

endpackage

### rtl/grid_wall_follower.sv
// Sequence: load and start pass through exec and out; read adds a wait state for the
// registered memory read; a step probes the tried neighbors one at a time on the single-port
// grid memory, and skips probing once the exit is reached.
// Requests are taken one at a time, each only after the previous result has left the walker;
// the output register holds a result while the next request is taken.
// Reset: runner at (0,0) facing east, exit flag and registers cleared; grid undefined
// until loaded.
`timescale 1ns / 1ps
module grid_wall_follower (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cell_row[3:0], cell_col[7:4], cell_code[10:8], zero
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // runner_row[3:0], runner_col[7:4], heading[9:8],
	                              // read_code[12:10], at_exit[13], zero
);

	gwf_pkg::cfg_t cfg_q;
	gwf_pkg::req_t req;
	gwf_pkg::res_t res, res_q;
	logic          res_valid, res_ready, m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gwf_pkg::REG_START_ROW: cfg_q.start_row <= cfg_data;
				gwf_pkg::REG_START_COL: cfg_q.start_col <= cfg_data;
				gwf_pkg::REG_EXIT_ROW:  cfg_q.exit_row  <= cfg_data;
				gwf_pkg::REG_EXIT_COL:  cfg_q.exit_col  <= cfg_data;
				default:                cfg_q           <= cfg_q;
			endcase
		end
	end

	assign req.kind = gwf_pkg::kind_t'(s_tuser);
	assign req.row  = s_tdata[3:0];
	assign req.col  = s_tdata[7:4];
	assign req.code = s_tdata[10:8];

	gwf_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.at_exit, res_q.read_code, res_q.heading,
		res_q.col, res_q.row};

endmodule

### rtl/gwf_grid_ram.sv
// Single-port grid memory with registered read data
`timescale 1ns / 1ps
module gwf_grid_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 3
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/gwf_walker.sv
// Request sequencer: cell load, start, read and right-hand walk steps over the grid memory
`timescale 1ns / 1ps
`include "grid_wall_follower_assert.svh"
module gwf_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  gwf_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_ready,
	input  gwf_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output gwf_pkg::res_t res
);

	gwf_pkg::state_t state_q, state_nxt;
	gwf_pkg::req_t   req_q;
	gwf_pkg::pos_t   pos_row_q, pos_col_q;
	gwf_pkg::dir_t   facing_q;
	logic            finished_q;
	logic [1:0]      try_q;
	gwf_pkg::code_t  rd_q;

	logic            ram_en, ram_we;
	gwf_pkg::addr_t  ram_addr;
	gwf_pkg::code_t  ram_wdata, ram_rdata;

	gwf_pkg::dir_t   cur_h, nxt_h;
	logic [4:0]      cur_r, cur_c, nxt_r, nxt_c;
	logic            cur_in, pos_in, req_in, start_in;
	gwf_pkg::code_t  probe_code;
	logic            probe_open, probe_exit, last_try, req_fire;

	gwf_grid_ram #(
		.DEPTH (gwf_pkg::DEPTH),
		.WIDTH (gwf_pkg::CODE_W)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign req_fire   = req_valid && req_ready;
	assign cur_h      = facing_q + gwf_pkg::turn_of(try_q);
	assign nxt_h      = facing_q + gwf_pkg::turn_of(try_q + 2'd1);
	assign cur_r      = gwf_pkg::step_row(pos_row_q, cur_h);
	assign cur_c      = gwf_pkg::step_col(pos_col_q, cur_h);
	assign nxt_r      = gwf_pkg::step_row(pos_row_q, nxt_h);
	assign nxt_c      = gwf_pkg::step_col(pos_col_q, nxt_h);
	assign cur_in     = gwf_pkg::in_grid(cur_r, cur_c);
	assign pos_in     = gwf_pkg::in_grid({1'b0, pos_row_q}, {1'b0, pos_col_q});
	assign req_in     = gwf_pkg::in_grid({1'b0, req_q.row}, {1'b0, req_q.col});
	assign start_in   = gwf_pkg::in_grid({1'b0, cfg.start_row}, {1'b0, cfg.start_col});
	assign probe_code = cur_in ? ram_rdata : gwf_pkg::CODE_WALL;
	assign probe_open = probe_code != gwf_pkg::CODE_WALL;
	assign probe_exit = (cur_r[3:0] == cfg.exit_row) && (cur_c[3:0] == cfg.exit_col);
	assign last_try   = try_q == gwf_pkg::TRY_LEFT;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gwf_pkg::ST_IDLE: begin
				if (req_fire) state_nxt = gwf_pkg::ST_EXEC;
			end
			gwf_pkg::ST_EXEC: begin
				if (req_q.kind == gwf_pkg::KIND_READ) begin
					state_nxt = gwf_pkg::ST_RDWAIT;
				end else if (req_q.kind == gwf_pkg::KIND_STEP && !finished_q) begin
					state_nxt = gwf_pkg::ST_PROBE;
				end else begin
					state_nxt = gwf_pkg::ST_OUT;
				end
			end
			gwf_pkg::ST_RDWAIT: state_nxt = gwf_pkg::ST_OUT;
			gwf_pkg::ST_PROBE: begin
				if (probe_open || last_try) state_nxt = gwf_pkg::ST_OUT;
			end
			gwf_pkg::ST_OUT: begin
				if (res_ready) state_nxt = gwf_pkg::ST_IDLE;
			end
			default: state_nxt = gwf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = gwf_pkg::CODE_OPEN;
		unique case (state_q)
			gwf_pkg::ST_IDLE: req_ready = 1'b1;
			gwf_pkg::ST_EXEC: begin
				unique case (req_q.kind)
					gwf_pkg::KIND_LOAD: begin
						ram_en    = req_in;
						ram_we    = 1'b1;
						ram_addr  = gwf_pkg::cell_addr(req_q.row, req_q.col);
						ram_wdata = req_q.code;
					end
					gwf_pkg::KIND_START: begin
						ram_en    = start_in;
						ram_we    = 1'b1;
						ram_addr  = gwf_pkg::cell_addr(cfg.start_row, cfg.start_col);
						ram_wdata = gwf_pkg::CODE_END;
					end
					gwf_pkg::KIND_STEP: begin
						ram_en   = !finished_q;
						ram_addr = gwf_pkg::cell_addr(cur_r[3:0], cur_c[3:0]);
					end
					gwf_pkg::KIND_READ: begin
						ram_en   = 1'b1;
						ram_addr = gwf_pkg::cell_addr(req_q.row, req_q.col);
					end
					default: ram_en = 1'b0;
				endcase
			end
			gwf_pkg::ST_RDWAIT: ram_en = 1'b0;
			gwf_pkg::ST_PROBE: begin
				if (probe_open) begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = gwf_pkg::cell_addr(cur_r[3:0], cur_c[3:0]);
					if (probe_exit) begin
						ram_wdata = gwf_pkg::CODE_END;
					end else if (probe_code == gwf_pkg::CODE_VISITED) begin
						ram_wdata = gwf_pkg::CODE_BACK;
					end else begin
						ram_wdata = gwf_pkg::CODE_VISITED;
					end
				end else if (!last_try) begin
					ram_en   = 1'b1;
					ram_addr = gwf_pkg::cell_addr(nxt_r[3:0], nxt_c[3:0]);
				end else begin
					ram_en    = pos_in;
					ram_we    = 1'b1;
					ram_addr  = gwf_pkg::cell_addr(pos_row_q, pos_col_q);
					ram_wdata = gwf_pkg::CODE_BACK;
				end
			end
			gwf_pkg::ST_OUT: res_valid = 1'b1;
			default: req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gwf_pkg::ST_IDLE;
			pos_row_q  <= '0;
			pos_col_q  <= '0;
			facing_q   <= gwf_pkg::DIR_EAST;
			finished_q <= 1'b0;
			try_q      <= gwf_pkg::TRY_RIGHT;
		end else begin
			state_q <= state_nxt;
			if (state_q == gwf_pkg::ST_IDLE) try_q <= gwf_pkg::TRY_RIGHT;
			if (state_q == gwf_pkg::ST_EXEC) begin
				if (req_q.kind == gwf_pkg::KIND_START) begin
					pos_row_q  <= cfg.start_row;
					pos_col_q  <= cfg.start_col;
					facing_q   <= gwf_pkg::DIR_EAST;
					finished_q <= (cfg.start_row == cfg.exit_row) &&
						(cfg.start_col == cfg.exit_col);
				end
			end
			if (state_q == gwf_pkg::ST_PROBE) begin
				if (probe_open) begin
					pos_row_q <= cur_r[3:0];
					pos_col_q <= cur_c[3:0];
					facing_q  <= cur_h;
					if (probe_exit) finished_q <= 1'b1;
				end else if (!last_try) begin
					try_q <= try_q + 2'd1;
				end else begin
					facing_q <= facing_q + gwf_pkg::TURN_AROUND;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) req_q <= req;
		if (state_q == gwf_pkg::ST_EXEC) rd_q <= gwf_pkg::CODE_OPEN;
		if (state_q == gwf_pkg::ST_RDWAIT) rd_q <= req_in ? ram_rdata : gwf_pkg::CODE_OPEN;
	end

	assign res.row       = pos_row_q;
	assign res.col       = pos_col_q;
	assign res.heading   = facing_q;
	assign res.read_code = rd_q;
	assign res.at_exit   = finished_q;

	`GWF_ASSERT(a_fire_to_exec, clk, arst_n, req_fire |=> state_q == gwf_pkg::ST_EXEC)
	`GWF_ASSERT_NEVER(a_idle_no_ram, clk, arst_n, state_q == gwf_pkg::ST_IDLE && ram_en)
	`GWF_ASSERT(a_idle_pos_hold, clk, arst_n, (state_q == gwf_pkg::ST_IDLE) |=> $stable(pos_row_q) && $stable(pos_col_q) && $stable(facing_q))
	`GWF_ASSERT_NEVER(a_done_step_quiet, clk, arst_n, state_q == gwf_pkg::ST_EXEC && req_q.kind == gwf_pkg::KIND_STEP && finished_q && ram_en)

endmodule

### tb/sv/tb_top.sv
// Testbench for grid_wall_follower: directed table, maze walks under random stalls, checked
`timescale 1ns / 1ps
module tb_top;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic            is_cfg;
		logic [1:0]      reg_idx;
		gwf_pkg::pos_t   reg_val;
		gwf_pkg::kind_t  kind;
		gwf_pkg::pos_t   row;
		gwf_pkg::pos_t   col;
		gwf_pkg::code_t  code;
		logic            typed;
		gwf_pkg::res_t   want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	gwf_pkg::code_t maze [16][16];
	gwf_pkg::pos_t  run_row = '0;
	gwf_pkg::pos_t  run_col = '0;
	gwf_pkg::dir_t  run_dir = gwf_pkg::DIR_EAST;
	logic           at_goal = 1'b0;
	gwf_pkg::pos_t  cfg_sr = '0;
	gwf_pkg::pos_t  cfg_sc = '0;
	gwf_pkg::pos_t  cfg_er = '0;
	gwf_pkg::pos_t  cfg_ec = '0;

	gwf_pkg::res_t pending_results[$];
	script_row_t   script[$];
	int            fails = 0;
	int            items_sent = 0;
	int            stalled = 0;
	int            send_idle_pct = 8;
	int            recv_idle_pct = 54;
	bit            want_hold = 1'b0;
	bit            hold_armed = 1'b0;
	bit            hold_used = 1'b0;
	int            hold_left = 0;

	grid_wall_follower i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic void walk_once();
		gwf_pkg::dir_t  h;
		int             nr;
		int             nc;
		int             k;
		gwf_pkg::code_t seen;
		logic           moved;
		moved = 1'b0;
		for (k = 0; k < 3 && !moved; k++) begin
			case (k)
				0: begin
					h = run_dir + gwf_pkg::TURN_RIGHT;
				end
				1: begin
					h = run_dir + gwf_pkg::TURN_NONE;
				end
				default: begin
					h = run_dir + gwf_pkg::TURN_LEFT;
				end
			endcase
			nr = int'(run_row) + (h == gwf_pkg::DIR_SOUTH ? 1 : 0) -
				(h == gwf_pkg::DIR_NORTH ? 1 : 0);
			nc = int'(run_col) + (h == gwf_pkg::DIR_EAST ? 1 : 0) -
				(h == gwf_pkg::DIR_WEST ? 1 : 0);
			if (nr < 0 || nc < 0 || nr >= gwf_pkg::GRID_SIDE || nc >= gwf_pkg::GRID_SIDE) begin
				seen = gwf_pkg::CODE_WALL;
			end else begin
				seen = maze[nr][nc];
			end
			if (seen != gwf_pkg::CODE_WALL) begin
				maze[nr][nc] = (seen == gwf_pkg::CODE_VISITED) ? gwf_pkg::CODE_BACK :
					gwf_pkg::CODE_VISITED;
				run_row = gwf_pkg::pos_t'(nr);
				run_col = gwf_pkg::pos_t'(nc);
				run_dir = h;
				moved = 1'b1;
				if (run_row == cfg_er && run_col == cfg_ec) begin
					maze[nr][nc] = gwf_pkg::CODE_END;
					at_goal = 1'b1;
				end
			end
		end
		// dead end: mark and turn around
		if (!moved) begin
			maze[run_row][run_col] = gwf_pkg::CODE_BACK;
			run_dir = run_dir + gwf_pkg::TURN_AROUND;
		end
	endfunction

	function automatic gwf_pkg::res_t apply_request(gwf_pkg::kind_t k, gwf_pkg::pos_t r,
			gwf_pkg::pos_t c, gwf_pkg::code_t cd);
		gwf_pkg::res_t o;
		o.read_code = gwf_pkg::CODE_OPEN;
		case (k)
			gwf_pkg::KIND_LOAD: begin
				maze[r][c] = cd;
			end
			gwf_pkg::KIND_START: begin
				run_row = cfg_sr;
				run_col = cfg_sc;
				run_dir = gwf_pkg::DIR_EAST;
				maze[cfg_sr][cfg_sc] = gwf_pkg::CODE_END;
				at_goal = (cfg_sr == cfg_er && cfg_sc == cfg_ec);
			end
			gwf_pkg::KIND_STEP: begin
				if (!at_goal) walk_once();
			end
			default: begin
				o.read_code = maze[r][c];
			end
		endcase
		o.row = run_row;
		o.col = run_col;
		o.heading = run_dir;
		o.at_exit = at_goal;
		return o;
	endfunction

	function automatic script_row_t rq(gwf_pkg::kind_t k, int r, int c, int cd);
		script_row_t x;
		x.is_cfg = 1'b0;
		x.reg_idx = gwf_pkg::REG_START_ROW;
		x.reg_val = '0;
		x.kind = k;
		x.row = gwf_pkg::pos_t'(r);
		x.col = gwf_pkg::pos_t'(c);
		x.code = gwf_pkg::code_t'(cd);
		x.typed = 1'b0;
		x.want = '0;
		return x;
	endfunction

	function automatic script_row_t rt(gwf_pkg::kind_t k, int r, int c, int cd,
			int wr, int wc, gwf_pkg::dir_t wh, gwf_pkg::code_t wcode, logic wexit);
		script_row_t x;
		x = rq(k, r, c, cd);
		x.typed = 1'b1;
		x.want.row = gwf_pkg::pos_t'(wr);
		x.want.col = gwf_pkg::pos_t'(wc);
		x.want.heading = wh;
		x.want.read_code = wcode;
		x.want.at_exit = wexit;
		return x;
	endfunction

	function automatic script_row_t cf(logic [1:0] idx, int v);
		script_row_t x;
		x = rq(gwf_pkg::KIND_LOAD, 0, 0, 0);
		x.is_cfg = 1'b1;
		x.reg_idx = idx;
		x.reg_val = gwf_pkg::pos_t'(v);
		return x;
	endfunction

	function automatic gwf_pkg::pos_t pick_pos();
		if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) != 0) ? 4'd15 : 4'd0;
		return gwf_pkg::pos_t'($urandom_range(0, 15));
	endfunction

	function automatic gwf_pkg::pos_t near(gwf_pkg::pos_t p, int span);
		int v;
		v = int'(p) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) v = 0;
		if (v > 15) v = 15;
		return gwf_pkg::pos_t'(v);
	endfunction

	function automatic gwf_pkg::code_t maze_code();
		int p;
		p = int'($urandom_range(0, 99));
		if (p < 50) return gwf_pkg::CODE_OPEN;
		if (p < 85) return gwf_pkg::CODE_WALL;
		return gwf_pkg::code_t'($urandom_range(0, 7));
	endfunction

	task automatic send_req(gwf_pkg::kind_t k, gwf_pkg::pos_t r, gwf_pkg::pos_t c,
			gwf_pkg::code_t cd, logic typed = 1'b0, gwf_pkg::res_t want = '0);
		gwf_pkg::res_t guess;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {5'b0, cd, c, r};
		do @(posedge clk); while (s_tready !== 1'b1);
		guess = apply_request(k, r, c, cd);
		pending_results.push_back(typed ? want : guess);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, gwf_pkg::pos_t val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gwf_pkg::REG_START_ROW: cfg_sr = val;
			gwf_pkg::REG_START_COL: cfg_sc = val;
			gwf_pkg::REG_EXIT_ROW:  cfg_er = val;
			default:                cfg_ec = val;
		endcase
	endtask

	task automatic run_episode();
		gwf_pkg::pos_t sr;
		gwf_pkg::pos_t sc;
		gwf_pkg::pos_t er;
		gwf_pkg::pos_t ec;
		int            pick;
		int            n;
		int            i;
		sr = pick_pos();
		sc = pick_pos();
		pick = int'($urandom_range(0, 9));
		if (pick == 0) begin
			er = sr;
			ec = sc;
		end else if (pick < 3) begin
			er = pick_pos();
			ec = pick_pos();
		end else begin
			er = near(sr, 4);
			ec = near(sc, 4);
		end
		write_reg(gwf_pkg::REG_START_ROW, sr);
		write_reg(gwf_pkg::REG_START_COL, sc);
		write_reg(gwf_pkg::REG_EXIT_ROW, er);
		write_reg(gwf_pkg::REG_EXIT_COL, ec);
		// lay out a patch of maze around start and exit
		n = int'($urandom_range(6, 30));
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				send_req(gwf_pkg::KIND_LOAD, near(er, 3), near(ec, 3), maze_code());
			end else begin
				send_req(gwf_pkg::KIND_LOAD, near(sr, 4), near(sc, 4), maze_code());
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			send_req(gwf_pkg::KIND_START, gwf_pkg::pos_t'($urandom), gwf_pkg::pos_t'($urandom),
				gwf_pkg::code_t'($urandom));
		end
		if (want_hold) begin
			hold_armed = 1'b1;
			want_hold = 1'b0;
		end
		n = int'($urandom_range(8, 40));
		for (i = 0; i < n; i++) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 76) begin
				send_req(gwf_pkg::KIND_STEP, gwf_pkg::pos_t'($urandom),
					gwf_pkg::pos_t'($urandom), gwf_pkg::code_t'($urandom));
			end else if (pick < 86) begin
				send_req(gwf_pkg::KIND_READ, near(run_row, 1), near(run_col, 1),
					gwf_pkg::code_t'($urandom));
			end else if (pick < 93) begin
				send_req(gwf_pkg::KIND_LOAD, gwf_pkg::pos_t'($urandom),
					gwf_pkg::pos_t'($urandom), gwf_pkg::code_t'($urandom));
			end else if (pick < 96) begin
				send_req(gwf_pkg::KIND_START, gwf_pkg::pos_t'($urandom),
					gwf_pkg::pos_t'($urandom), gwf_pkg::code_t'($urandom));
			end else begin
				send_req(gwf_pkg::KIND_READ, gwf_pkg::pos_t'($urandom),
					gwf_pkg::pos_t'($urandom), gwf_pkg::code_t'($urandom));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_armed && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		gwf_pkg::res_t want;
		gwf_pkg::res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[3:0];
			got.col = m_tdata[7:4];
			got.heading = m_tdata[9:8];
			got.read_code = m_tdata[12:10];
			got.at_exit = m_tdata[13];
			if (pending_results.size() == 0) begin
				fails++;
				$display("%0t: result with no request pending: %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.row != want.row || got.col != want.col ||
						got.heading != want.heading || got.read_code != want.read_code ||
						got.at_exit != want.at_exit) begin
					fails++;
					$display("%0t: mismatch expected row %0d col %0d heading %0d code %0d exit %0d",
						$time, want.row, want.col, want.heading, want.read_code, want.at_exit);
					$display("%0t:          actual row %0d col %0d heading %0d code %0d exit %0d",
						$time, got.row, got.col, got.heading, got.read_code, got.at_exit);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stalled = 0;
			end else begin
				stalled = stalled + 1;
			end
			if (stalled >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int c;
		foreach (maze[i, j]) maze[i][j] = gwf_pkg::CODE_OPEN;

		// corner dead end, start on exit, then a short walk along the bottom row
		script.push_back(rt(gwf_pkg::KIND_LOAD, 0, 1, gwf_pkg::CODE_WALL, 0, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b0));
		script.push_back(rt(gwf_pkg::KIND_LOAD, 1, 0, gwf_pkg::CODE_WALL, 0, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b0));
		script.push_back(rt(gwf_pkg::KIND_STEP, 15, 15, 7, 0, 0,
			gwf_pkg::DIR_WEST, gwf_pkg::CODE_OPEN, 1'b0));
		script.push_back(rt(gwf_pkg::KIND_READ, 0, 0, 0, 0, 0,
			gwf_pkg::DIR_WEST, gwf_pkg::CODE_BACK, 1'b0));
		script.push_back(rt(gwf_pkg::KIND_START, 9, 6, 5, 0, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b1));
		script.push_back(rt(gwf_pkg::KIND_STEP, 0, 0, 0, 0, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b1));
		script.push_back(rt(gwf_pkg::KIND_READ, 0, 0, 0, 0, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_END, 1'b1));
		script.push_back(cf(gwf_pkg::REG_START_ROW, 15));
		script.push_back(cf(gwf_pkg::REG_START_COL, 0));
		script.push_back(cf(gwf_pkg::REG_EXIT_ROW, 15));
		script.push_back(cf(gwf_pkg::REG_EXIT_COL, 3));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 15, 1, 5));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 15, 2, gwf_pkg::CODE_VISITED));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 15, 3, gwf_pkg::CODE_OPEN));
		script.push_back(rt(gwf_pkg::KIND_START, 0, 0, 0, 15, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b0));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));
		script.push_back(rq(gwf_pkg::KIND_READ, 15, 2, 0));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));
		script.push_back(rq(gwf_pkg::KIND_READ, 15, 3, 0));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 15, 15, 7));
		script.push_back(rt(gwf_pkg::KIND_READ, 15, 15, 0, 15, 3,
			gwf_pkg::DIR_EAST, 3'd7, 1'b1));
		script.push_back(rt(gwf_pkg::KIND_START, 0, 0, 0, 15, 0,
			gwf_pkg::DIR_EAST, gwf_pkg::CODE_OPEN, 1'b0));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));
		script.push_back(rq(gwf_pkg::KIND_READ, 15, 1, 0));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 15, 2, gwf_pkg::CODE_WALL));
		script.push_back(rq(gwf_pkg::KIND_LOAD, 14, 1, gwf_pkg::CODE_OPEN));
		script.push_back(rq(gwf_pkg::KIND_STEP, 0, 0, 0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_req(script[i].kind, script[i].row, script[i].col, script[i].code,
					script[i].typed, script[i].want);
			end
		end

		// fill every cell so no walk probes an unloaded one
		for (r = 0; r < 16; r++) begin
			for (c = 0; c < 16; c++) begin
				send_req(gwf_pkg::KIND_LOAD, gwf_pkg::pos_t'(r), gwf_pkg::pos_t'(c), maze_code());
			end
		end

		while (items_sent < 650) run_episode();
		send_idle_pct = 54;
		recv_idle_pct = 8;
		while (items_sent < 1150) run_episode();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		want_hold = 1'b1;
		while (items_sent < 1700) run_episode();

		drain();
		repeat (12) @(posedge clk);
		if (fails == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
